// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and defaults for the sorted priority queue core
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int PRIORITY_BITS_DEF = 16;
    localparam int PAYLOAD_BITS_DEF  = 32;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // broadcast command to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctl_t;

endpackage

// ----- rtl/stable_sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// bounded min-first priority queue, stable for equal priorities
// ----------------------------------------------------------------------------
// An item (insert or remove) is taken at any edge where start is high; busy
// never rises, so one item is taken per clock. Its result shows on the result
// ports in the next cycle, for that single cycle, marked by done. The work is
// done by the row of CAPACITY cells, each of which compares its own priority
// with the incoming one in the same cycle and then keeps its entry, takes its
// left neighbor's, takes the new entry or takes its right neighbor's. Slot 0
// is the head. There is no clearing pass after reset.
module stable_sorted_priority_queue_core #(
    parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF,
    localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            operation,
    input  logic signed [PRIORITY_BITS-1:0] entry_priority,
    input  logic        [PAYLOAD_BITS-1:0]  payload_tag,
    output logic                            done,
    output logic        [1:0]               status,
    output logic signed [PRIORITY_BITS-1:0] removed_priority,
    output logic        [PAYLOAD_BITS-1:0]  removed_payload,
    output logic        [CNT_W-1:0]         occupancy
);

    logic signed [PRIORITY_BITS-1:0] prio_w  [CAPACITY];
    logic        [PAYLOAD_BITS-1:0]  pay_w   [CAPACITY];
    logic                            valid_w [CAPACITY];
    logic                            shift_w [CAPACITY];

    spq_pkg::cell_ctl_t ctl;
    logic               take;
    logic               is_remove;
    logic               full;
    logic               empty;

    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            done_reg, done_next;
    spq_pkg::status_t                status_reg, status_next;
    logic signed [PRIORITY_BITS-1:0] rprio_reg, rprio_next;
    logic        [PAYLOAD_BITS-1:0]  rpay_reg, rpay_next;

    assign busy      = 1'b0;
    assign take      = start && !busy;
    assign is_remove = (spq_pkg::op_t'(operation) == spq_pkg::OP_REMOVE);
    assign full      = valid_w[CAPACITY-1];
    assign empty     = !valid_w[0];
    assign ctl.ins   = take && !is_remove && !full;
    assign ctl.rem   = take && is_remove && !empty;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [PRIORITY_BITS-1:0] lp, rp;
        logic        [PAYLOAD_BITS-1:0]  lpay, rpay;
        logic                            lv, ls, rv;

        if (i == 0)
        begin : g_head
            // head sees an always-valid, never-shifting left side
            assign lp   = '0;
            assign lpay = '0;
            assign lv   = 1'b1;
            assign ls   = 1'b0;
        end
        else
        begin : g_mid
            assign lp   = prio_w[i-1];
            assign lpay = pay_w[i-1];
            assign lv   = valid_w[i-1];
            assign ls   = shift_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign rp   = '0;
            assign rpay = '0;
            assign rv   = 1'b0;
        end
        else
        begin : g_body
            assign rp   = prio_w[i+1];
            assign rpay = pay_w[i+1];
            assign rv   = valid_w[i+1];
        end

        spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .PAYLOAD_BITS  (PAYLOAD_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_prio    (entry_priority),
            .new_pay     (payload_tag),
            .left_prio   (lp),
            .left_pay    (lpay),
            .left_valid  (lv),
            .left_shift  (ls),
            .right_prio  (rp),
            .right_pay   (rpay),
            .right_valid (rv),
            .prio        (prio_w[i]),
            .pay         (pay_w[i]),
            .valid       (valid_w[i]),
            .shift       (shift_w[i])
        );
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        done_next   = take;
        status_next = spq_pkg::ST_INSERTED;
        rprio_next  = '0;
        rpay_next   = '0;
        if (take)
        begin
            if (!is_remove)
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = spq_pkg::ST_INSERTED;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next = spq_pkg::ST_REMOVED;
                    rprio_next  = prio_w[0];
                    rpay_next   = pay_w[0];
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rprio_reg  <= rprio_next;
        rpay_reg   <= rpay_next;
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign removed_priority = rprio_reg;
    assign removed_payload  = rpay_reg;
    assign occupancy        = cnt_reg;

endmodule

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry and trades with its neighbors
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spq_pkg::cell_ctl_t              ctl,
    input  logic signed [PRIORITY_BITS-1:0] new_prio,
    input  logic        [PAYLOAD_BITS-1:0]  new_pay,
    input  logic signed [PRIORITY_BITS-1:0] left_prio,
    input  logic        [PAYLOAD_BITS-1:0]  left_pay,
    input  logic                            left_valid,
    input  logic                            left_shift,
    input  logic signed [PRIORITY_BITS-1:0] right_prio,
    input  logic        [PAYLOAD_BITS-1:0]  right_pay,
    input  logic                            right_valid,
    output logic signed [PRIORITY_BITS-1:0] prio,
    output logic        [PAYLOAD_BITS-1:0]  pay,
    output logic                            valid,
    output logic                            shift
);

    logic signed [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic        [PAYLOAD_BITS-1:0]  pay_reg, pay_next;
    logic                            valid_reg, valid_next;

    // entry moves right unless it is valid and not larger than the new one
    assign shift = !(valid_reg && (prio_reg <= new_prio));

    always_comb
    begin
        prio_next  = prio_reg;
        pay_next   = pay_reg;
        valid_next = valid_reg;
        if (ctl.ins)
        begin
            valid_next = valid_reg | left_valid;
            if (shift)
            begin
                if (left_shift)
                begin
                    prio_next = left_prio;
                    pay_next  = left_pay;
                end
                else
                begin
                    // first shifting cell is the insertion point
                    prio_next = new_prio;
                    pay_next  = new_pay;
                end
            end
        end
        else if (ctl.rem)
        begin
            prio_next  = right_prio;
            pay_next   = right_pay;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        pay_reg  <= pay_next;
    end

    assign prio  = prio_reg;
    assign pay   = pay_reg;
    assign valid = valid_reg;

endmodule

// ----- rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks for the sorted priority queue core
// ----------------------------------------------------------------------------
module spq_checker #(
    parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF,
    localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic        [1:0]               status,
    input logic signed [PRIORITY_BITS-1:0] removed_priority,
    input logic        [PAYLOAD_BITS-1:0]  removed_payload,
    input logic        [CNT_W-1:0]         occupancy
);

    // one result for every item, in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("item taken without a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without an item");

    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != spq_pkg::ST_REMOVED) |->
            (removed_priority == '0 && removed_payload == '0))
        else $error("removed fields not zero");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == spq_pkg::ST_FULL) |-> (occupancy == CNT_W'(CAPACITY)))
        else $error("full reported below capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == spq_pkg::ST_EMPTY) |-> (occupancy == '0))
        else $error("empty reported with entries held");

endmodule

bind stable_sorted_priority_queue_core spq_checker #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
) u_spq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .status           (status),
    .removed_priority (removed_priority),
    .removed_payload  (removed_payload),
    .occupancy        (occupancy)
);
